// ===== hw/rtl/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg
// shared types for the insertion sorter cell chain
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int unsigned VALUE_W = 32;

  // contents of one cell of the chain
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } isort_slot_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                      load;   // insert data into the chain
    logic                      drain;  // shift every cell one place toward cell 0
    logic signed [VALUE_W-1:0] data;
  } isort_ctrl_t;

endpackage

// ===== hw/rtl/isort_cell.sv =====
// ----------------------------------------------------------------------------
// isort_cell
// one compare-and-shift cell of the sorting chain
// ----------------------------------------------------------------------------
module isort_cell
  import isort_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  isort_ctrl_t ctrl,
  input  isort_slot_t left,      // neighbor closer to cell 0
  input  logic        left_ins,  // neighbor also takes a new value this cycle
  input  isort_slot_t right,     // neighbor farther from cell 0
  output isort_slot_t slot,
  output logic        ins
);

  isort_slot_t slot_next;

  // strict compare keeps equal values in arrival order
  assign ins = !slot.valid || (ctrl.data < slot.value);

  always_comb begin
    slot_next = slot;
    priority if (ctrl.drain) begin
      slot_next = right;
    end else if (ctrl.load && ins) begin
      if (left_ins) begin
        slot_next = left;
      end else begin
        slot_next.valid = 1'b1;
        slot_next.value = ctrl.data;
      end
    end else begin
      slot_next = slot;
    end
  end

  // only the valid bit needs a reset, the value follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.value <= slot_next.value;
  end

endmodule

// ===== hw/rtl/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter
// batch sorter for signed 32-bit values on a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage:
//   the slave stream carries one value per transfer; tlast closes a batch.
//   every accepted value is inserted in place into a chain of DEPTH cells in
//   the cycle it is accepted, so the chain always holds the batch in
//   ascending order. a value that arrives with the chain full is dropped and
//   the overflow flag is raised for the batch, also for the tlast transfer.
//   after the tlast transfer the chain drains through the master stream,
//   smallest first, from cell 0, one transfer per cycle while m_tready is high;
//   tlast marks the greatest value and tuser carries the overflow flag on every
//   transfer.
// throughput and latency:
//   one input transfer per cycle while loading. the first result is shown
//   the cycle after the tlast transfer. no input is taken during the drain,
//   so the next batch waits until the last result of this one has left.
// stalls and reset:
//   while m_tready is low the chain holds and the result stays on the port.
//   rst empties the chain and clears the count and the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // end_of_run
  output logic [0:0]  m_tuser    // [0] overflow
);

  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  // controller state
  logic               draining;
  logic [COUNT_W-1:0] count;
  logic               dropped;

  isort_ctrl_t        ctrl;
  isort_slot_t        slot [DEPTH];
  logic               ins  [DEPTH];

  logic in_xfer;
  logic out_xfer;
  logic full;
  logic run_done;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign full     = (count == COUNT_W'(DEPTH));
  // the last result leaves when cell 1 is already empty
  assign run_done = out_xfer && !slot[1].valid;

  assign s_tready = !draining;

  always_comb begin
    ctrl.load  = in_xfer && !full;
    ctrl.drain = out_xfer;
    ctrl.data  = s_tdata;
  end

  // the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    isort_slot_t left_slot;
    isort_slot_t right_slot;
    logic        left_ins;

    if (i == 0) begin : g_head
      assign left_slot = '0;
      assign left_ins  = 1'b0;
    end else begin : g_body
      assign left_slot = slot[i-1];
      assign left_ins  = ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_link
      assign right_slot = slot[i+1];
    end

    isort_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .left     (left_slot),
      .left_ins (left_ins),
      .right    (right_slot),
      .slot     (slot[i]),
      .ins      (ins[i])
    );
  end

  // batch bookkeeping; a drain and an input transfer never meet
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      count    <= '0;
      dropped  <= 1'b0;
    end else begin
      if (run_done) begin
        draining <= 1'b0;
        count    <= '0;
        dropped  <= 1'b0;
      end else if (in_xfer) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + COUNT_W'(1);
        end
        if (s_tlast) begin
          draining <= 1'b1;
        end
      end
    end
  end

  // results come straight from cell 0
  assign m_tvalid   = draining;
  assign m_tdata    = slot[0].value;
  assign m_tlast    = !slot[1].valid;
  assign m_tuser[0] = dropped;

  // a batch always holds at least one value while it drains
  assert property (@(posedge clk) disable iff (rst)
    draining |-> slot[0].valid)
    else $error("drain with empty head cell");

  // the count never passes the chain length
  assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // a closing input starts the drain
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tlast) |=> draining)
    else $error("batch close did not start drain");

  // the final result ends the drain with the chain empty
  assert property (@(posedge clk) disable iff (rst)
    run_done |=> (!draining && !slot[0].valid && count == '0))
    else $error("chain not empty after run");

endmodule
